// ===== rtl/hbmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Heartbeat membership table package
// Shared types, sizes and codes of the heartbeat membership table.
// ----------------------------------------------------------------------------
package hbmt_pkg;

   // Number of member slots in the table.
   localparam int TABLE_DEPTH = 16;
   // Slot index width and the width of a counter that can also hold the depth.
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Commands.
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Result kinds.
   localparam logic [2:0] KIND_ADDED   = 3'd0;
   localparam logic [2:0] KIND_REMOVED = 3'd1;
   localparam logic [2:0] KIND_GOSSIP  = 3'd2;
   localparam logic [2:0] KIND_DROPPED = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;

   // Configuration register indexes and port widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_PORT     = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [15:0] entry_id;
      logic [15:0] entry_port;
      logic [31:0] entry_heartbeat;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] member_id;
      logic [15:0] member_port;
      logic [31:0] member_heartbeat;
      logic        last;
   } rsp_type;

   // One table slot as it is held in the slot memory.
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] port;
      logic [31:0] heartbeat;
      logic [31:0] stamp;
   } slot_type;

   // Access control from the sequencer to the slot store.
   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             set_valid;
      logic             clr_valid;
      logic [IDX_W-1:0] clr_addr;
   } slot_ctrl_type;

endpackage

// ===== rtl/heartbeat_membership_table.sv =====
// ----------------------------------------------------------------------------
// Heartbeat membership table
// Membership list with heartbeat merge, aging, removal and gossip selection.
// ----------------------------------------------------------------------------
// A beat is offered on req_data with start high; it is taken at a rising edge
// where start is high and busy is low, and busy stays high until the beat has
// given all of its results. An update beat merges one received entry and gives
// exactly one result. A tick beat raises the own heartbeat, merges the own
// entry, removes aged entries, names gossip targets and ends with a done result.
// Each result appears on rsp_data for one cycle with rsp_strobe high; the
// receiver has no way to stall, and the final result of a beat has last set.
// The configuration port takes a write on every edge with csr_write high; the
// user must use it only while busy is low, as the block does not enforce this.
// Walk: every pass walks the slot memory one slot per cycle through its
// single registered read port; an update pass ends early when the entry is
// found. The first result of an update leaves the block when the entry is
// found or at the end of the walk, and the block is ready for the next beat
// in the cycle its last result is on the ports.
// Reset empties the table, clears the own heartbeat and loads the default
// limits and own identity; no clearing pass is needed.
// ----------------------------------------------------------------------------
module heartbeat_membership_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hbmt_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output hbmt_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [hbmt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hbmt_pkg::CSR_DATA_W-1:0]     csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_REMOVE,
      ST_GOSSIP
   } state_type;

   // Configuration registers.
   logic [7:0]  fail_limit_ff;
   logic [7:0]  remove_limit_ff;
   logic [15:0] own_id_ff;
   logic [15:0] own_port_ff;

   // Sequencer state.
   state_type                    state_ff, state_in;
   logic                         op_ff, op_in;
   logic [15:0]                  key_id_ff, key_id_in;
   logic [15:0]                  key_port_ff, key_port_in;
   logic [31:0]                  key_hb_ff, key_hb_in;
   logic [31:0]                  now_ff, now_in;
   logic [31:0]                  self_hb_ff, self_hb_in;
   logic [hbmt_pkg::CNT_W-1:0]   rd_addr_ff, rd_addr_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [hbmt_pkg::IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic                         free_found_ff, free_found_in;
   logic [hbmt_pkg::IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   hbmt_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // Slot store interface.
   hbmt_pkg::slot_ctrl_type              store_ctrl;
   hbmt_pkg::slot_type                   store_wr;
   hbmt_pkg::slot_type                   store_rd;
   logic [hbmt_pkg::TABLE_DEPTH-1:0]     store_valid;

   // Per-slot checks on the slot whose read data is returning this cycle.
   logic        issue;
   logic        pass_end;
   logic        chk_live;
   logic        key_match;
   logic [31:0] slot_age;
   logic        age_removes;
   logic        age_gossips;

   hbmt_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .wr_data (store_wr),
      .rd_data (store_rd),
      .valid   (store_valid)
   );

   // A pass walks the addresses in order; it ends when the last read returned.
   assign issue    = rd_addr_ff != hbmt_pkg::CNT_W'(hbmt_pkg::TABLE_DEPTH);
   assign pass_end = !chk_vld_ff && !issue;

   // Slot data is only looked at when the slot is valid.
   assign chk_live    = store_valid[chk_idx_ff];
   assign key_match   = (store_rd.id == key_id_ff) && (store_rd.port == key_port_ff);
   assign slot_age    = now_ff - store_rd.stamp;
   assign age_removes = slot_age >= {24'd0, remove_limit_ff};
   assign age_gossips = slot_age < {24'd0, fail_limit_ff};

   // Both merge writes store the key with the current time as its stamp.
   assign store_wr = '{id: key_id_ff, port: key_port_ff, heartbeat: key_hb_ff,
                       stamp: now_ff};

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   function automatic hbmt_pkg::rsp_type make_rsp(logic [2:0] kind, logic [15:0] id,
                                                  logic [15:0] port, logic [31:0] hb,
                                                  logic last);
      hbmt_pkg::rsp_type r;
      r.kind             = kind;
      r.member_id        = id;
      r.member_port      = port;
      r.member_heartbeat = hb;
      r.last             = last;
      return r;
   endfunction

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_id_in     = key_id_ff;
      key_port_in   = key_port_ff;
      key_hb_in     = key_hb_ff;
      now_in        = now_ff;
      self_hb_in    = self_hb_ff;
      rd_addr_in    = rd_addr_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      store_ctrl.rd_addr   = rd_addr_ff[hbmt_pkg::IDX_W-1:0];
      store_ctrl.wr_en     = 1'b0;
      store_ctrl.wr_addr   = chk_idx_ff;
      store_ctrl.set_valid = 1'b0;
      store_ctrl.clr_valid = 1'b0;
      store_ctrl.clr_addr  = chk_idx_ff;

      // Keep the read pipeline moving in every walking state.
      if (state_ff != ST_IDLE) begin
         if (issue) begin
            rd_addr_in = rd_addr_ff + hbmt_pkg::CNT_W'(1);
            chk_vld_in = 1'b1;
            chk_idx_in = rd_addr_ff[hbmt_pkg::IDX_W-1:0];
         end else begin
            chk_vld_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_data.cmd;
               now_in        = req_data.now;
               rd_addr_in    = '0;
               chk_vld_in    = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_MERGE;
               if (req_data.cmd == hbmt_pkg::CMD_TICK) begin
                  self_hb_in  = self_hb_ff + 32'd1;
                  key_id_in   = own_id_ff;
                  key_port_in = own_port_ff;
                  key_hb_in   = self_hb_ff + 32'd1;
               end else begin
                  key_id_in   = req_data.entry_id;
                  key_port_in = req_data.entry_port;
                  key_hb_in   = req_data.entry_heartbeat;
               end
            end
         end

         ST_MERGE: begin
            if (chk_vld_ff) begin
               if (chk_live && key_match) begin
                  // Found: the slot only moves forward on a strictly larger heartbeat.
                  if (key_hb_ff > store_rd.heartbeat) begin
                     store_ctrl.wr_en = 1'b1;
                  end
                  rd_addr_in = '0;
                  chk_vld_in = 1'b0;
                  if (op_ff == hbmt_pkg::CMD_UPDATE) begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = make_rsp(hbmt_pkg::KIND_DONE, key_id_ff, key_port_ff,
                                              (key_hb_ff > store_rd.heartbeat) ?
                                              key_hb_ff : store_rd.heartbeat, 1'b1);
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_REMOVE;
                  end
               end else if (!chk_live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
            end else if (pass_end) begin
               // Not found: insert into the lowest free slot, or drop.
               rsp_strobe_in = 1'b1;
               if (free_found_ff) begin
                  store_ctrl.wr_en     = 1'b1;
                  store_ctrl.wr_addr   = free_idx_ff;
                  store_ctrl.set_valid = 1'b1;
                  rsp_data_in = make_rsp(hbmt_pkg::KIND_ADDED, key_id_ff, key_port_ff,
                                         key_hb_ff, op_ff == hbmt_pkg::CMD_UPDATE);
               end else begin
                  rsp_data_in = make_rsp(hbmt_pkg::KIND_DROPPED, key_id_ff, key_port_ff,
                                         key_hb_ff, op_ff == hbmt_pkg::CMD_UPDATE);
               end
               rd_addr_in = '0;
               state_in   = (op_ff == hbmt_pkg::CMD_UPDATE) ? ST_IDLE : ST_REMOVE;
            end
         end

         ST_REMOVE: begin
            if (chk_vld_ff && chk_live && age_removes) begin
               store_ctrl.clr_valid = 1'b1;
               rsp_strobe_in        = 1'b1;
               rsp_data_in = make_rsp(hbmt_pkg::KIND_REMOVED, store_rd.id, store_rd.port,
                                      store_rd.heartbeat, 1'b0);
            end
            if (pass_end) begin
               rd_addr_in = '0;
               state_in   = ST_GOSSIP;
            end
         end

         ST_GOSSIP: begin
            if (chk_vld_ff && chk_live && age_gossips) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp(hbmt_pkg::KIND_GOSSIP, store_rd.id, store_rd.port,
                                        store_rd.heartbeat, 1'b0);
            end
            if (pass_end) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp(hbmt_pkg::KIND_DONE, own_id_ff, own_port_ff,
                                        self_hb_ff, 1'b1);
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         self_hb_ff    <= '0;
         rd_addr_ff    <= '0;
         chk_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         self_hb_ff    <= self_hb_in;
         rd_addr_ff    <= rd_addr_in;
         chk_vld_ff    <= chk_vld_in;
         free_found_ff <= free_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff       <= op_in;
      key_id_ff   <= key_id_in;
      key_port_ff <= key_port_in;
      key_hb_ff   <= key_hb_in;
      now_ff      <= now_in;
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes; the user must make them only while the block is idle, as it does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         fail_limit_ff   <= 8'd5;
         remove_limit_ff <= 8'd20;
         own_id_ff       <= 16'd1;
         own_port_ff     <= 16'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            hbmt_pkg::CSR_FAIL_LIMIT:   fail_limit_ff   <= csr_data[7:0];
            hbmt_pkg::CSR_REMOVE_LIMIT: remove_limit_ff <= csr_data[7:0];
            hbmt_pkg::CSR_OWN_ID:       own_id_ff       <= csr_data;
            hbmt_pkg::CSR_OWN_PORT:     own_port_ff     <= csr_data;
         endcase
      end
   end

endmodule

// ===== rtl/hbmt_slot_store.sv =====
// ----------------------------------------------------------------------------
// Heartbeat membership slot store
// Slot memory with a registered read port and the per-slot valid flags.
// ----------------------------------------------------------------------------
module hbmt_slot_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hbmt_pkg::slot_ctrl_type              ctrl,
   input  hbmt_pkg::slot_type                   wr_data,
   output hbmt_pkg::slot_type                   rd_data,
   output logic [hbmt_pkg::TABLE_DEPTH-1:0]     valid
);

   hbmt_pkg::slot_type                   mem [hbmt_pkg::TABLE_DEPTH];
   hbmt_pkg::slot_type                   rd_data_ff;
   logic [hbmt_pkg::TABLE_DEPTH-1:0]     valid_ff;

   // The read returns the old contents when it meets a write to the same slot.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ctrl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ctrl.wr_en && ctrl.set_valid) begin
            valid_ff[ctrl.wr_addr] <= 1'b1;
         end
         if (ctrl.clr_valid) begin
            valid_ff[ctrl.clr_addr] <= 1'b0;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule
